@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ sv/bfra_pkg.sv @@
// Package for the best-fit region allocator: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfra_pkg;

  localparam int ADDR_BITS    = 32;
  localparam int LEN_BITS     = ADDR_BITS + 1;
  localparam int DEV_BITS     = 8;
  localparam int SIZE_BITS    = 32;
  localparam int REQ_BITS     = 2;
  localparam int STAT_BITS    = 3;
  localparam int FREE_ENTRIES_DEF = 64;
  localparam int BUF_ENTRIES_DEF  = 64;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 112;

  localparam logic [LEN_BITS-1:0] POOL_RESET = LEN_BITS'(64'h8000_0000);
  localparam logic [LEN_BITS-1:0] SPACE_TOP  = {1'b1, {ADDR_BITS{1'b0}}};

  localparam logic [REQ_BITS-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_LOCATE = 2'd2;

  localparam logic [STAT_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_NO_FIT  = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_ZERO    = 3'd4;

  localparam logic [1:0] SCAN_ALLOC  = 2'd0;
  localparam logic [1:0] SCAN_BUFHIT = 2'd1;
  localparam logic [1:0] SCAN_LOCATE = 2'd2;
  localparam logic [1:0] SCAN_NEIGH  = 2'd3;

  typedef struct packed {
    logic                 load;
    logic                 init;
    logic                 scan_start;
    logic [1:0]           scan_mode;
    logic                 calc;
    logic                 commit;
    logic                 emit;
    logic [STAT_BITS-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [REQ_BITS-1:0] req_type;
    logic                zero_size;
    logic                scan_done;
    logic                slot_found;
    logic                fit_found;
    logic                buf_found;
    logic                place_ok;
    logic                out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/bfra_ctrl.sv @@
// Controller state machine of the region allocator.
// Depends on bfra_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module bfra_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_wr_en,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  bfra_pkg::sts_t    sts,
  output bfra_pkg::cmd_t    cmd
);
  import bfra_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SCAN_A = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_SCAN_F = 4'd5;
  localparam logic [3:0] S_CHECK2 = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0]           state, state_next;
  logic [STAT_BITS-1:0] res_code, res_code_next;

  assign s_tready = (state == S_IDLE) && !cfg_wr_en;

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd           = '0;
    cmd.code      = res_code;
    case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.req_type)
          REQ_ALLOC: begin
            if (sts.zero_size) begin
              res_code_next = ST_ZERO;
              state_next    = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_ALLOC;
              state_next     = S_SCAN_A;
            end
          end
          REQ_FREE: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_BUFHIT;
            state_next     = S_SCAN_A;
          end
          REQ_LOCATE: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_LOCATE;
            state_next     = S_SCAN_A;
          end
          default: begin
            res_code_next = ST_OK;
            state_next    = S_RESULT;
          end
        endcase
      end
      S_SCAN_A: begin
        if (sts.scan_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (sts.req_type)
          REQ_ALLOC: begin
            if (!sts.slot_found) begin
              res_code_next = ST_FULL;
              state_next    = S_RESULT;
            end else if (!sts.fit_found) begin
              res_code_next = ST_NO_FIT;
              state_next    = S_RESULT;
            end else begin
              cmd.calc   = 1'b1;
              state_next = S_WRITE;
            end
          end
          REQ_FREE: begin
            if (!sts.buf_found) begin
              res_code_next = ST_UNKNOWN;
              state_next    = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = SCAN_NEIGH;
              state_next     = S_SCAN_F;
            end
          end
          default: begin
            res_code_next = sts.buf_found ? ST_OK : ST_UNKNOWN;
            state_next    = S_RESULT;
          end
        endcase
      end
      S_SCAN_F: begin
        if (sts.scan_done) state_next = S_CHECK2;
      end
      S_CHECK2: begin
        if (!sts.place_ok) begin
          res_code_next = ST_FULL;
          state_next    = S_RESULT;
        end else begin
          cmd.calc   = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.commit    = 1'b1;
        res_code_next = ST_OK;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
    if (cfg_wr_en) state_next = S_INIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      res_code <= ST_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/bfra_datapath.sv @@
// Datapath of the region allocator: free and buffer tables, scan unit,
// update arithmetic and result register. Depends on bfra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfra_datapath #(
  parameter int FREE_ENTRIES = bfra_pkg::FREE_ENTRIES_DEF,
  parameter int BUF_ENTRIES  = bfra_pkg::BUF_ENTRIES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [bfra_pkg::LEN_BITS-1:0]    cfg_wr_data,
  input  wire  [bfra_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire  [bfra_pkg::REQ_BITS-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [bfra_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [bfra_pkg::STAT_BITS-1:0]   m_tuser,
  input  bfra_pkg::cmd_t                   cmd,
  output bfra_pkg::sts_t                   sts
);
  import bfra_pkg::*;

  localparam int MAXN = (FREE_ENTRIES > BUF_ENTRIES) ? FREE_ENTRIES : BUF_ENTRIES;
  localparam int CW   = $clog2(MAXN + 1);
  localparam int FIW  = $clog2(FREE_ENTRIES);
  localparam int BIW  = (BUF_ENTRIES > 1) ? $clog2(BUF_ENTRIES) : 1;
  localparam logic [CW-1:0] LAST_MAX  = CW'(MAXN - 1);
  localparam logic [CW-1:0] LAST_FREE = CW'(FREE_ENTRIES - 1);
  localparam logic [CW-1:0] LAST_BUF  = CW'(BUF_ENTRIES - 1);
  localparam logic [CW-1:0] N_FREE    = CW'(FREE_ENTRIES);
  localparam logic [CW-1:0] N_BUF     = CW'(BUF_ENTRIES);

  logic [ADDR_BITS-1:0] free_start_mem [FREE_ENTRIES];
  logic [LEN_BITS-1:0]  free_len_mem   [FREE_ENTRIES];
  logic [ADDR_BITS-1:0] buf_base_mem   [BUF_ENTRIES];
  logic [LEN_BITS-1:0]  buf_len_mem    [BUF_ENTRIES];
  logic [DEV_BITS-1:0]  buf_dev_mem    [BUF_ENTRIES];
  logic [FREE_ENTRIES-1:0] free_valid;
  logic [BUF_ENTRIES-1:0]  buf_valid;

  logic [LEN_BITS-1:0]  pool;
  logic [LEN_BITS-1:0]  pool_clamped;

  logic [REQ_BITS-1:0]  req;
  logic [SIZE_BITS-1:0] size;
  logic [ADDR_BITS-1:0] addr;
  logic [DEV_BITS-1:0]  dev;

  logic [1:0]           mode;
  logic                 active, pv;
  logic [CW-1:0]        idx, idx_d, last;
  logic [ADDR_BITS-1:0] rd_fstart, rd_bbase;
  logic [LEN_BITS-1:0]  rd_flen, rd_blen;
  logic [DEV_BITS-1:0]  rd_bdev;

  logic                 slot_found, fit_found, b_found, lo_found, hi_found, spare_found;
  logic [BIW-1:0]       slot, b;
  logic [FIW-1:0]       fit, lo, hi, spare;
  logic [ADDR_BITS-1:0] best_start, lo_start, b_base, offs, abase;
  logic [LEN_BITS-1:0]  best_len, b_len, lo_len, hi_len, end_addr, calc;
  logic [DEV_BITS-1:0]  b_dev;

  logic [FIW-1:0]       fi;
  logic [BIW-1:0]       bi;
  logic                 in_free, in_buf;
  logic [LEN_BITS-1:0   ] size_ext, addr_ext, fend, ldiff;

  logic                 fw_en;
  logic [FIW-1:0]       fw_addr, wa;
  logic [ADDR_BITS-1:0] fw_start;
  logic [LEN_BITS-1:0]  fw_len;

  assign pool_clamped = pool[LEN_BITS-1] ? SPACE_TOP : pool;
  assign size_ext = {1'b0, size};
  assign addr_ext = {1'b0, addr};
  assign fi       = idx_d[FIW-1:0];
  assign bi       = idx_d[BIW-1:0];
  assign in_free  = idx_d < N_FREE;
  assign in_buf   = idx_d < N_BUF;
  assign fend     = {1'b0, rd_fstart} + rd_flen;
  assign ldiff    = addr_ext - {1'b0, rd_bbase};
  assign wa       = lo_found ? lo : (hi_found ? hi : spare);

  always_comb begin
    case (mode)
      SCAN_ALLOC: last = LAST_MAX;
      SCAN_NEIGH: last = LAST_FREE;
      default:    last = LAST_BUF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= POOL_RESET;
    end else if (cfg_wr_en) begin
      pool <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= s_tuser;
      size <= s_tdata[SIZE_BITS-1:0];
      addr <= s_tdata[SIZE_BITS+ADDR_BITS-1:SIZE_BITS];
      dev  <= s_tdata[SIZE_BITS+ADDR_BITS+DEV_BITS-1:SIZE_BITS+ADDR_BITS];
    end
  end

  // scan sequencer: one table entry per cycle; each entry's read data is registered, then processed
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pv     <= 1'b0;
    end else if (cmd.scan_start) begin
      active <= 1'b1;
      pv     <= 1'b0;
    end else begin
      pv <= active;
      if (active && idx == last) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      mode <= cmd.scan_mode;
      idx  <= '0;
    end else if (active) begin
      idx <= idx + 1'b1;
    end
    idx_d     <= idx;
    rd_fstart <= free_start_mem[idx[FIW-1:0]];
    rd_flen   <= free_len_mem[idx[FIW-1:0]];
    rd_bbase  <= buf_base_mem[idx[BIW-1:0]];
    rd_blen   <= buf_len_mem[idx[BIW-1:0]];
    rd_bdev   <= buf_dev_mem[idx[BIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      slot_found  <= 1'b0;
      fit_found   <= 1'b0;
      lo_found    <= 1'b0;
      hi_found    <= 1'b0;
      spare_found <= 1'b0;
      if (cmd.scan_mode != SCAN_NEIGH) b_found <= 1'b0;
      if (cmd.scan_mode == SCAN_NEIGH) end_addr <= addr_ext + b_len;
    end else if (pv) begin
      case (mode)
        SCAN_ALLOC: begin
          if (in_buf && !buf_valid[bi] && !slot_found) begin
            slot_found <= 1'b1;
            slot       <= bi;
          end
          if (in_free && free_valid[fi] && rd_flen >= size_ext &&
              (!fit_found || rd_flen < best_len ||
               (rd_flen == best_len && rd_fstart < best_start))) begin
            fit_found  <= 1'b1;
            fit        <= fi;
            best_start <= rd_fstart;
            best_len   <= rd_flen;
          end
        end
        SCAN_BUFHIT: begin
          if (buf_valid[bi] && rd_bbase == addr && !b_found) begin
            b_found <= 1'b1;
            b       <= bi;
            b_len   <= rd_blen;
            b_dev   <= rd_bdev;
          end
        end
        SCAN_LOCATE: begin
          if (buf_valid[bi] && addr >= rd_bbase && ldiff < rd_blen && !b_found) begin
            b_found <= 1'b1;
            b       <= bi;
            b_base  <= rd_bbase;
            b_len   <= rd_blen;
            b_dev   <= rd_bdev;
            offs    <= ldiff[ADDR_BITS-1:0];
          end
        end
        default: begin
          if (!free_valid[fi]) begin
            if (!spare_found) begin
              spare_found <= 1'b1;
              spare       <= fi;
            end
          end else begin
            if (fend == addr_ext) begin
              lo_found <= 1'b1;
              lo       <= fi;
              lo_start <= rd_fstart;
              lo_len   <= rd_flen;
            end
            if ({1'b0, rd_fstart} == end_addr) begin
              hi_found <= 1'b1;
              hi       <= fi;
              hi_len   <= rd_flen;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (req == REQ_ALLOC) calc <= best_len - size_ext;
      else                  calc <= b_len + (hi_found ? hi_len : '0);
    end
    if (cmd.commit && req == REQ_ALLOC) abase <= best_start + calc[ADDR_BITS-1:0];
  end

  always_comb begin
    fw_en    = 1'b0;
    fw_addr  = '0;
    fw_start = '0;
    fw_len   = '0;
    if (cmd.init) begin
      fw_en    = 1'b1;
      fw_start = ADDR_BITS'(SPACE_TOP - pool_clamped);
      fw_len   = pool_clamped;
    end else if (cmd.commit && req == REQ_ALLOC) begin
      fw_en    = 1'b1;
      fw_addr  = fit;
      fw_start = best_start;
      fw_len   = calc;
    end else if (cmd.commit) begin
      fw_en    = 1'b1;
      fw_addr  = wa;
      fw_start = lo_found ? lo_start : addr;
      fw_len   = lo_found ? lo_len + calc : calc;
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      free_start_mem[fw_addr] <= fw_start;
      free_len_mem[fw_addr]   <= fw_len;
    end
    if (cmd.commit && req == REQ_ALLOC) begin
      buf_base_mem[slot] <= best_start + calc[ADDR_BITS-1:0];
      buf_len_mem[slot]  <= size_ext;
      buf_dev_mem[slot]  <= dev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      free_valid <= '0;
      buf_valid  <= '0;
    end else if (cmd.init) begin
      free_valid[0] <= pool_clamped != '0;
    end else if (cmd.commit) begin
      if (req == REQ_ALLOC) begin
        free_valid[fit] <= calc != '0;
        buf_valid[slot] <= 1'b1;
      end else begin
        free_valid[wa] <= 1'b1;
        if (lo_found && hi_found) free_valid[hi] <= 1'b0;
        buf_valid[b] <= 1'b0;
      end
    end
  end

  // result register: m_tdata holds base, size, offset, device
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= cmd.code;
      m_tdata <= '0;
      if (cmd.code == ST_OK) begin
        case (req)
          REQ_ALLOC:  m_tdata <= OUT_DATA_W'({dev, {ADDR_BITS{1'b0}}, size_ext, abase});
          REQ_FREE:   m_tdata <= OUT_DATA_W'({b_dev, {ADDR_BITS{1'b0}}, b_len, addr});
          REQ_LOCATE: m_tdata <= OUT_DATA_W'({b_dev, offs, b_len, b_base});
          default:    m_tdata <= '0;
        endcase
      end
    end
  end

  assign sts.req_type   = req;
  assign sts.zero_size  = size == '0;
  assign sts.scan_done  = pv && !active;
  assign sts.slot_found = slot_found;
  assign sts.fit_found  = fit_found;
  assign sts.buf_found  = b_found;
  assign sts.place_ok   = lo_found || hi_found || spare_found;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

`default_nettype wire

@@ sv/best_fit_region_allocator_core.sv @@
// Best-fit region allocator with coalescing free list.
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one request; s_tuser is the
//   request kind (allocate, free, locate). m_tvalid/m_tready/m_tdata/m_tuser
//   return exactly one result per request; m_tuser is the status code.
//   cfg_wr_en/cfg_wr_data load the pool size and rebuild both tables; write
//   it only while the block is idle.
// Scanning: allocate and locate make one pass over the table memories, free
//   two when its buffer is found; a zero-size allocate or an unknown kind makes
//   none. A pass goes at one entry per cycle, set by the single read port of each table.
// Throughput: one request at a time; s_tready is high only when idle.
// Reset: synchronous rst restores a 2^31 byte pool; the first cycle after
//   reset or a pool write loads the initial free region, s_tready is low.
// Stall: the result register holds while m_tready is low; the next request
//   is accepted and worked on, and waits at its end until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_region_allocator_core #(
  parameter int FREE_ENTRIES   = bfra_pkg::FREE_ENTRIES_DEF,
  parameter int BUFFER_ENTRIES = bfra_pkg::BUF_ENTRIES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wr_en,
  input  wire  [bfra_pkg::LEN_BITS-1:0]    cfg_wr_data,   // pool_size
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [bfra_pkg::IN_DATA_W-1:0]   s_tdata,  // alloc_size, address, device
  input  wire  [bfra_pkg::REQ_BITS-1:0]    s_tuser,  // req_type
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [bfra_pkg::OUT_DATA_W-1:0]  m_tdata,
  // base_address, buffer_size, offset, buffer_device, zero pad
  output logic [bfra_pkg::STAT_BITS-1:0]   m_tuser   // status
);
  import bfra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfra_datapath #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .BUF_ENTRIES  (BUFFER_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

@@ sv/bfra_checker.sv @@
// Port-level checker for the region allocator and its bind.
// Depends on bfra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bfra_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              cfg_wr_en,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [bfra_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire [bfra_pkg::STAT_BITS-1:0]    m_tuser
);
  import bfra_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_NOW(a_err_zero, clk, rst, m_tvalid && m_tuser != ST_OK, m_tdata == '0)
  `ASSERT_NEXT(a_cfg_init, clk, rst, cfg_wr_en, !s_tready)
  `ASSERT_NEXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind best_fit_region_allocator_core bfra_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .cfg_wr_en (cfg_wr_en),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for best_fit_region_allocator_core: a predictor tracks
// the free-region and buffer tables and checks every result in order.
// Depends on bfra_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import bfra_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_NONE = 2'd3;
  localparam int NFREE = 64;
  localparam int NBUF = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [REQ_BITS-1:0] kind;
    logic [31:0] size;
    logic [31:0] addr;
    logic [7:0] dev;
  } request_t;

  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [31:0] base;
    logic [32:0] size;
    logic [31:0] offset;
    logic [7:0] dev;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [LEN_BITS-1:0] cfg_wr_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [REQ_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_BITS-1:0] m_tuser;

  request_t pending_requests[$];
  answer_t expected_answers[$];

  // predictor tables
  logic [32:0] pool_bytes;
  logic [31:0] fr_start[NFREE];
  logic [32:0] fr_len[NFREE];
  logic fr_valid[NFREE];
  logic [31:0] bf_base[NBUF];
  logic [32:0] bf_len[NBUF];
  logic [7:0] bf_dev[NBUF];
  logic bf_valid[NBUF];

  int mismatches = 0;
  int checked = 0;
  int status_seen[8];
  int phases_run = 0;
  int cycle_count = 0;
  int stall_cycles = 0;
  logic calm;

  best_fit_region_allocator_core u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  assign calm = cycle_count >= 30000 && cycle_count < 50000;

  function automatic void rebuild_tables(logic [32:0] value);
    logic [32:0] ps;
    ps = (value > SPACE_TOP) ? SPACE_TOP : value;
    for (int i = 0; i < NFREE; i++) begin
      fr_valid[i] = 0;
      fr_start[i] = '0;
      fr_len[i] = '0;
    end
    for (int i = 0; i < NBUF; i++) bf_valid[i] = 0;
    if (ps != 0) begin
      fr_start[0] = 32'(SPACE_TOP - ps);
      fr_len[0] = ps;
      fr_valid[0] = 1;
    end
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int slot, fit, b, lo, hi, spare;
    logic [32:0] base33, end33;
    a = '{ST_OK, '0, '0, '0, '0};
    slot = -1; fit = -1; b = -1; lo = -1; hi = -1; spare = -1;
    case (r.kind)
      REQ_ALLOC: begin
        if (r.size == 0) begin
          a.status = ST_ZERO;
          return a;
        end
        for (int i = NBUF - 1; i >= 0; i--) if (!bf_valid[i]) slot = i;
        if (slot < 0) begin
          a.status = ST_FULL;
          return a;
        end
        for (int i = 0; i < NFREE; i++) begin
          if (!fr_valid[i] || fr_len[i] < {1'b0, r.size}) continue;
          if (fit < 0 || fr_len[i] < fr_len[fit] ||
              (fr_len[i] == fr_len[fit] && fr_start[i] < fr_start[fit])) fit = i;
        end
        if (fit < 0) begin
          a.status = ST_NO_FIT;
          return a;
        end
        base33 = {1'b0, fr_start[fit]} + fr_len[fit] - {1'b0, r.size};
        fr_len[fit] = fr_len[fit] - {1'b0, r.size};
        if (fr_len[fit] == 0) fr_valid[fit] = 0;
        bf_base[slot] = base33[31:0];
        bf_len[slot] = {1'b0, r.size};
        bf_dev[slot] = r.dev;
        bf_valid[slot] = 1;
        a = '{ST_OK, base33[31:0], {1'b0, r.size}, '0, r.dev};
      end
      REQ_FREE: begin
        for (int i = NBUF - 1; i >= 0; i--) if (bf_valid[i] && bf_base[i] == r.addr) b = i;
        if (b < 0) begin
          a.status = ST_UNKNOWN;
          return a;
        end
        end33 = {1'b0, r.addr} + bf_len[b];
        for (int i = 0; i < NFREE; i++) begin
          if (!fr_valid[i]) begin
            if (spare < 0) spare = i;
            continue;
          end
          if ({1'b0, fr_start[i]} + fr_len[i] == {1'b0, r.addr}) lo = i;
          if ({1'b0, fr_start[i]} == end33) hi = i;
        end
        if (lo >= 0 && hi >= 0) begin
          fr_len[lo] = fr_len[lo] + bf_len[b] + fr_len[hi];
          fr_valid[hi] = 0;
        end else if (lo >= 0) begin
          fr_len[lo] = fr_len[lo] + bf_len[b];
        end else if (hi >= 0) begin
          fr_start[hi] = r.addr;
          fr_len[hi] = fr_len[hi] + bf_len[b];
        end else if (spare >= 0) begin
          fr_start[spare] = r.addr;
          fr_len[spare] = bf_len[b];
          fr_valid[spare] = 1;
        end else begin
          a.status = ST_FULL;
          return a;
        end
        bf_valid[b] = 0;
        a = '{ST_OK, r.addr, bf_len[b], '0, bf_dev[b]};
      end
      REQ_LOCATE: begin
        for (int i = 0; i < NBUF; i++) begin
          if (bf_valid[i] && r.addr >= bf_base[i] &&
              {1'b0, r.addr - bf_base[i]} < bf_len[i]) begin
            a = '{ST_OK, bf_base[i], bf_len[i], r.addr - bf_base[i], bf_dev[i]};
            return a;
          end
        end
        a.status = ST_UNKNOWN;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void queue_request(logic [REQ_BITS-1:0] kind, logic [31:0] size,
                                        logic [31:0] addr, logic [7:0] dev);
    request_t r;
    r = '{kind, size, addr, dev};
    pending_requests.push_back(r);
    expected_answers.push_back(predict_answer(r));
  endfunction

  function automatic int pick_live_buffer();
    int live[$];
    for (int i = 0; i < NBUF; i++) if (bf_valid[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic logic [31:0] random_alloc_size();
    int pick;
    logic [32:0] ps;
    pick = $urandom_range(0, 99);
    ps = (pool_bytes > SPACE_TOP) ? SPACE_TOP : pool_bytes;
    if (pick < 3) return '0;
    if (pick < 60) return 32'($urandom_range(1, 64));
    if (pick < 88 && ps > 8) return 32'(({$urandom, $urandom} % (ps / 4)) + 1);
    return $urandom;
  endfunction

  function automatic void queue_random_request();
    int pick, b;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    b = pick_live_buffer();
    if (pick < 45) begin
      queue_request(REQ_ALLOC, random_alloc_size(), $urandom, 8'($urandom));
    end else if (pick < 75) begin
      if (b >= 0 && pick < 70) queue_request(REQ_FREE, $urandom, bf_base[b], 8'($urandom));
      else queue_request(REQ_FREE, $urandom, $urandom, 8'($urandom));
    end else if (pick < 96) begin
      if (b >= 0 && pick < 90) begin
        wide = {$urandom, $urandom} % 64'(bf_len[b]);
        queue_request(REQ_LOCATE, $urandom, bf_base[b] + 32'(wide), 8'($urandom));
      end else begin
        queue_request(REQ_LOCATE, $urandom, $urandom, 8'($urandom));
      end
    end else begin
      queue_request(REQ_NONE, $urandom, $urandom, 8'($urandom));
    end
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_answers.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool(logic [32:0] value);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    pool_bytes = value;
    rebuild_tables(value);
  endtask

  task automatic run_phase(logic [32:0] value, int count);
    write_pool(value);
    for (int i = 0; i < count; i++) queue_random_request();
    wait_idle();
    phases_run++;
  endtask

  initial begin
    pool_bytes = POOL_RESET;
    rebuild_tables(POOL_RESET);
    repeat (9) @(posedge clk);
    rst <= 0;

    queue_request(REQ_ALLOC, 32'd0, 32'h0, 8'h00);
    queue_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    queue_request(REQ_LOCATE, 32'h0, 32'hFFFF_FFFF, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'h8000_0000, 8'h00);
    queue_request(REQ_ALLOC, 32'h8000_0000, 32'h0, 8'hA5);
    queue_request(REQ_ALLOC, 32'd1, 32'h0, 8'h01);
    queue_request(REQ_LOCATE, 32'h0, 32'h8000_0000, 8'h00);
    queue_request(REQ_LOCATE, 32'h0, 32'hFFFF_FFFF, 8'h00);
    queue_request(REQ_LOCATE, 32'h0, 32'h0000_0000, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'h8000_0000, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'h8000_0000, 8'h00);
    queue_request(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    queue_request(REQ_ALLOC, 32'h10, 32'h0, 8'hFF);
    queue_request(REQ_ALLOC, 32'h10, 32'h0, 8'h5A);
    queue_request(REQ_ALLOC, 32'h7FFF_FFE0, 32'h0, 8'h3C);
    queue_request(REQ_LOCATE, 32'h0, 32'hFFFF_FFEF, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'hFFFF_FFF0, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'h8000_0000, 8'h00);
    queue_request(REQ_FREE, 32'h0, 32'hFFFF_FFE0, 8'h00);
    queue_request(REQ_ALLOC, 32'h8000_0000, 32'h0, 8'h77);
    wait_idle();
    for (int i = 0; i < 200; i++) queue_random_request();
    wait_idle();
    phases_run++;

    run_phase(33'd4096, 520);
    run_phase(33'd1, 150);
    run_phase(SPACE_TOP, 400);
    run_phase(33'd0, 100);
    run_phase(33'h1_FFFF_FFFF, 150);
    run_phase({1'($urandom_range(0, 1)), $urandom}, 300);
    run_phase(33'd65536, 100);

    $display("Checked %0d results over %0d pool settings.", checked, phases_run);
    $display("Status counts: ok %0d, no fit %0d, unknown %0d, full %0d, zero %0d.",
             status_seen[ST_OK], status_seen[ST_NO_FIT], status_seen[ST_UNKNOWN],
             status_seen[ST_FULL], status_seen[ST_ZERO]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    request_t r;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      s_tvalid <= 0;
      m_tready <= 0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 35;
      if (!s_tvalid || s_tready) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          r = pending_requests.pop_front();
          s_tvalid <= 1;
          s_tuser <= r.kind;
          s_tdata <= {r.dev, r.addr, r.size};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    answer_t e;
    answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[31:0], m_tdata[64:32], m_tdata[96:65], m_tdata[104:97]};
      checked++;
      status_seen[got.status]++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", got.status);
      end else begin
        e = expected_answers.pop_front();
        if (got != e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st %0d base %h size %h off %h dev %h",
                     e.status, e.base, e.size, e.offset, e.dev);
            $display("          got      st %0d base %h size %h off %h dev %h",
                     got.status, got.base, got.size, got.offset, got.dev);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
